// ===== hw/rtl/tmtw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer package
// Shared constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tmtw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned TAB_WIDTH  = 8;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  // Field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned LOC_W  = 11;
  localparam int unsigned CELL_W = 16;

  // Last cell moved up during a scroll
  localparam int unsigned SCROLL_LAST = (ROWS - 1) * COLUMNS - 1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

  // Cell value after reset
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

  // Configuration port
  localparam int unsigned         APB_ADDR_W   = 3;
  localparam int unsigned         APB_DATA_W   = 32;
  localparam logic                REG_ATTR_IDX = 1'b0;
  localparam logic [ATTR_W-1:0]   ATTR_RESET   = 8'h0F;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;   // capture item, clear per-item flags
    logic put;        // apply a character to cursor and screen
    logic home;       // cursor to top left
    logic rd_cell;    // read the addressed cell
    logic cap_cell;   // capture read data into the result
    logic scr_rd;     // read the cell one line below the counter
    logic scr_wr;     // write read data at the counter
    logic fill_wr;    // write a fill value at the counter
    logic fill_init;  // fill value is the reset cell
    logic cnt_zero;
    logic cnt_inc;
    logic load_out;   // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  put_scroll;
    logic  cnt_scr_last;
    logic  cnt_last;
    logic  out_free;
  } sts_t;

endpackage

// ===== hw/rtl/tmtw_cfg.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer configuration registers
// APB slave holding the text attribute byte.
// ----------------------------------------------------------------------------
module tmtw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tmtw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tmtw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tmtw_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [tmtw_pkg::ATTR_W-1:0]     attr_o
);
  import tmtw_pkg::*;

  logic [ATTR_W-1:0] attr_q, attr_d;
  logic              hit_attr;

  assign pready   = 1'b1;
  assign hit_attr = (paddr[2] == REG_ATTR_IDX);

  // Decode the write
  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && hit_attr) begin
      attr_d = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit_attr) begin
      prdata = {{(APB_DATA_W-ATTR_W){1'b0}}, attr_q};
    end
  end

  assign attr_o = attr_q;

endmodule

// ===== hw/rtl/tmtw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer controller
// Sequences each item: execute, scroll sweep, fill sweep, cell read, result.
// ----------------------------------------------------------------------------
module tmtw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tmtw_pkg::sts_t sts_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output tmtw_pkg::cmd_t cmd_o
);
  import tmtw_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_EXEC   = 8'b0000_0100,
    ST_CAP    = 8'b0000_1000,
    ST_SCR_RD = 8'b0001_0000,
    ST_SCR_WR = 8'b0010_0000,
    ST_FILL   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.fill_wr   = 1'b1;
        cmd_o.fill_init = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts_i.kind)
          KIND_PUT: begin
            cmd_o.put = 1'b1;
            if (sts_i.put_scroll) begin
              cmd_o.cnt_zero = 1'b1;
              state_d        = ST_SCR_RD;
            end else begin
              state_d = ST_DONE;
            end
          end
          KIND_CLEAR: begin
            cmd_o.home     = 1'b1;
            cmd_o.cnt_zero = 1'b1;
            state_d        = ST_FILL;
          end
          KIND_READ: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = ST_CAP;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_CAP: begin
        cmd_o.cap_cell = 1'b1;
        state_d        = ST_DONE;
      end
      ST_SCR_RD: begin
        cmd_o.scr_rd = 1'b1;
        state_d      = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd_o.scr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = sts_i.cnt_scr_last ? ST_FILL : ST_SCR_RD;
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Screen is never written while waiting for an item
  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(cmd_o.put || cmd_o.scr_wr || cmd_o.fill_wr))
    else $error("screen write while idle");

  // A finished fill sweep leaves the sweep
  a_fill_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FILL || state_q == ST_INIT) && sts_i.cnt_last)
      |=> (state_q == ST_DONE || state_q == ST_IDLE))
    else $error("fill sweep did not end");

  // Each accepted item starts executing next cycle
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");

endmodule

// ===== hw/rtl/tmtw_dp.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer datapath
// Item register, cursor, screen memory, sweep counter and output register.
// ----------------------------------------------------------------------------
module tmtw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmtw_pkg::cmd_t                cmd_i,
  output tmtw_pkg::sts_t                sts_o,
  input  logic [tmtw_pkg::ATTR_W-1:0]   attr_i,
  input  logic [tmtw_pkg::KIND_W-1:0]   in_kind_i,
  input  logic [tmtw_pkg::CHAR_W-1:0]   in_char_i,
  input  logic [tmtw_pkg::LOC_W-1:0]    in_addr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tmtw_pkg::COL_W-1:0]    out_col_o,
  output logic [tmtw_pkg::ROW_W-1:0]    out_row_o,
  output logic [tmtw_pkg::LOC_W-1:0]    out_loc_o,
  output logic [tmtw_pkg::CELL_W-1:0]   out_cell_o,
  output logic                          out_scrolled_o
);
  import tmtw_pkg::*;

  // Item register
  kind_e             kind_q;
  logic [CHAR_W-1:0] char_q;
  logic [LOC_W-1:0]  addr_q;

  // Cursor, counter, per-item results
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [LOC_W-1:0]  cnt_q;
  logic [CELL_W-1:0] cell_q;
  logic              scr_q;

  // Screen memory
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [LOC_W-1:0]  mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;

  // Output register
  logic              out_valid_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [LOC_W-1:0]  out_loc_q;
  logic [CELL_W-1:0] out_cell_q;
  logic              out_scr_q;

  // Put-character logic
  logic [COL_W:0]    col_ext, col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic              printable;
  logic              put_scroll;
  logic [LOC_W-1:0]  cur_loc;
  logic              addr_ok;

  assign cur_loc = LOC_W'(row_q) * LOC_W'(COLUMNS) + LOC_W'(col_q);
  assign addr_ok = (addr_q < LOC_W'(CELL_COUNT));

  // Next cursor for the held character
  always_comb begin
    col_ext   = {1'b0, col_q};
    col_nxt   = col_ext;
    row_nxt   = row_q;
    printable = 1'b0;
    case (char_q)
      CH_BS: begin
        if (col_q != '0) begin
          col_nxt = col_ext - 1'b1;
        end
      end
      CH_TAB: begin
        col_nxt = (col_ext & ~((COL_W+1)'(TAB_WIDTH - 1))) + (COL_W+1)'(TAB_WIDTH);
      end
      CH_CR: begin
        col_nxt = '0;
      end
      CH_LF: begin
        col_nxt = '0;
        row_nxt = row_q + 1'b1;
      end
      default: begin
        if (char_q >= CH_SPACE && char_q <= CH_DEL) begin
          printable = 1'b1;
          col_nxt   = col_ext + 1'b1;
        end
      end
    endcase
    // Wrap at the right edge
    if (col_nxt >= (COL_W+1)'(COLUMNS)) begin
      col_nxt = '0;
      row_nxt = row_q + 1'b1;
    end
    put_scroll = (row_nxt == ROW_W'(ROWS));
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= kind_e'(in_kind_i);
      char_q <= in_char_i;
      addr_q <= in_addr_i;
    end
  end

  // Cursor and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.home) begin
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_i.put) begin
        col_q <= col_nxt[COL_W-1:0];
        row_q <= put_scroll ? ROW_W'(ROWS - 1) : row_nxt;
      end
      if (cmd_i.cnt_zero) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Per-item results
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cell_q <= '0;
      scr_q  <= 1'b0;
    end else begin
      if (cmd_i.put) begin
        scr_q <= put_scroll;
      end
      if (cmd_i.cap_cell) begin
        cell_q <= addr_ok ? rd_q : '0;
      end
    end
  end

  // Memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q;
    mem_wd = rd_q;
    if (cmd_i.put && printable) begin
      mem_we = 1'b1;
      mem_wa = cur_loc;
      mem_wd = {attr_i, char_q};
    end else if (cmd_i.scr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.fill_wr) begin
      mem_we = 1'b1;
      mem_wd = cmd_i.fill_init ? RESET_CELL : {attr_i, CH_SPACE};
    end
    mem_re = cmd_i.scr_rd || (cmd_i.rd_cell && addr_ok);
    mem_ra = cmd_i.scr_rd ? (cnt_q + LOC_W'(COLUMNS)) : addr_q;
  end

  // Screen memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_col_q  <= col_q;
      out_row_q  <= row_q;
      out_loc_q  <= cur_loc;
      out_cell_q <= cell_q;
      out_scr_q  <= scr_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_col_o      = out_col_q;
  assign out_row_o      = out_row_q;
  assign out_loc_o      = out_loc_q;
  assign out_cell_o     = out_cell_q;
  assign out_scrolled_o = out_scr_q;

  // Status
  assign sts_o.kind         = kind_q;
  assign sts_o.put_scroll   = put_scroll;
  assign sts_o.cnt_scr_last = (cnt_q == LOC_W'(SCROLL_LAST));
  assign sts_o.cnt_last     = (cnt_q == LOC_W'(CELL_COUNT - 1));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  // Cursor row stays on screen
  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < ROW_W'(ROWS))
    else $error("cursor row off screen");

  // A scrolling result leaves the cursor on the last line
  a_scroll_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scr_q) |-> (out_row_q == ROW_W'(ROWS - 1)))
    else $error("scroll result not on last line");

endmodule

// ===== hw/rtl/text_mode_terminal_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer core
// 80x25 screen of attribute/character cells with a cursor; puts characters,
// clears the screen and reads cells.
//
//   channel   dir   handshake                  contents
//   s_axis    in    tvalid/tready              tuser kind, tdata char/address
//   m_axis    out   tvalid/tready              tdata cursor, cell, scrolled
//   apb       in    psel/penable/pready        text attribute at 0x0
//
// Sequence: a character or idle kind passes through execute and done, a read
// through execute, capture and done; a character that scrolls reads and then
// writes each moved cell and then fills the bottom line; a clear fills the
// whole screen. The block returns to idle before the next item is taken.
// After reset a clearing pass fills the screen before the first item is
// taken. A stalled result holds in the output register; the next item is
// taken meanwhile and completes into it once the result is taken.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // char_code[7:0], read_address[18:8]
  input  logic [1:0]                      s_axis_tuser,  // kind[1:0]
  // Result output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,  // cursor_column[6:0],
                                                         // cursor_row[11:7],
                                                         // cursor_location[22:12],
                                                         // cell_data[38:23], scrolled[39]
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tmtw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tmtw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tmtw_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tmtw_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [ATTR_W-1:0] attr;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [LOC_W-1:0]  out_loc;
  logic [CELL_W-1:0] out_cell;
  logic              out_scrolled;

  tmtw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr_o  (attr)
  );

  tmtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  tmtw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .attr_i         (attr),
    .in_kind_i      (s_axis_tuser),
    .in_char_i      (s_axis_tdata[7:0]),
    .in_addr_i      (s_axis_tdata[18:8]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_col_o      (out_col),
    .out_row_o      (out_row),
    .out_loc_o      (out_loc),
    .out_cell_o     (out_cell),
    .out_scrolled_o (out_scrolled)
  );

  // Pack the result
  assign m_axis_tdata = {out_scrolled, out_cell, out_loc, out_row, out_col};

endmodule

// ===== sim/text_mode_terminal_writer_core_tb.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer core testbench
// Sends put, clear, read and idle-kind items through the stream input. A
// mirror of the screen, cursor and text attribute predicts each cursor report.
// A short stimulus table goes first, with typed results at the extremes.
// Then come scrolling line runs and random traffic under several attributes,
// with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmtw_pkg::*;

  localparam int unsigned DIRECTED_N     = 25;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned END_SETTLE     = 50;
  localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = APB_ADDR_W'(4 * REG_ATTR_IDX);

  // Cursor report, laid out exactly as m_axis_tdata (MSB first)
  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
    logic [LOC_W-1:0]  loc;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } report_t;

  typedef struct packed {
    report_t want;
    logic    typed;
    report_t typed_want;
  } pending_t;

  typedef struct {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic [LOC_W-1:0]  addr;
    logic              typed;
    report_t           want;
  } stim_row_t;

  localparam report_t HOME_EMPTY = '0;
  localparam report_t HOME_BLANK = '{scrolled: 1'b0, cell_data: RESET_CELL,
                                     loc: '0, row: '0, col: '0};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;   // char_code[7:0], read_address[18:8]
  logic [1:0]            s_axis_tuser;   // kind[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;   // column, row, location, cell, scrolled
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Typed expectation travelling alongside the item on the input
  logic    row_typed;
  report_t row_want;

  // Screen mirror
  logic [CELL_W-1:0] screen_mirror [CELL_COUNT];
  int unsigned       cursor_col_mirror;
  int unsigned       cursor_row_mirror;
  logic [ATTR_W-1:0] attr_shadow;

  pending_t    pending_reports [$];
  int unsigned fail_count;
  int unsigned reports_checked;
  int unsigned scrolls_seen;
  int unsigned items_sent;
  int unsigned stall_cycles;
  bit          idle_en;
  bit          long_hold_done;

  stim_row_t directed_tbl [DIRECTED_N] = '{
    '{KIND_READ,  8'h00,    11'd0,    1'b1, HOME_BLANK},  // reset contents
    '{KIND_READ,  8'hFF,    11'd1999, 1'b1, HOME_BLANK},
    '{KIND_READ,  8'h00,    11'h7FF,  1'b1, HOME_EMPTY},  // out of range
    '{KIND_NONE,  8'hFF,    11'h7FF,  1'b1, HOME_EMPTY},
    '{KIND_PUT,   8'h00,    11'd0,    1'b1, HOME_EMPTY},  // ignored bytes
    '{KIND_PUT,   8'hFF,    11'h7FF,  1'b1, HOME_EMPTY},
    '{KIND_PUT,   8'h80,    11'd0,    1'b1, HOME_EMPTY},
    '{KIND_PUT,   8'h1F,    11'd0,    1'b1, HOME_EMPTY},
    '{KIND_PUT,   CH_BS,    11'd0,    1'b1, HOME_EMPTY},  // backspace at column 0
    '{KIND_PUT,   CH_SPACE, 11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   CH_DEL,   11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   8'h41,    11'd0,    1'b0, HOME_EMPTY},
    '{KIND_READ,  8'h00,    11'd2,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   CH_BS,    11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   CH_TAB,   11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   CH_TAB,   11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   8'h55,    11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   8'hAA,    11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   CH_CR,    11'd0,    1'b0, HOME_EMPTY},
    '{KIND_PUT,   CH_LF,    11'd0,    1'b0, HOME_EMPTY},
    '{KIND_READ,  8'h00,    11'h555,  1'b0, HOME_EMPTY},
    '{KIND_READ,  8'h00,    11'd2000, 1'b0, HOME_EMPTY},
    '{KIND_CLEAR, 8'h00,    11'd0,    1'b1, HOME_EMPTY},
    '{KIND_READ,  8'h00,    11'd1,    1'b1, HOME_BLANK},  // blank of attribute 0x0F
    '{KIND_NONE,  8'h00,    11'd0,    1'b1, HOME_EMPTY}
  };

  text_mode_terminal_writer_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one item to the screen mirror and return the cursor report
  function automatic report_t advance_screen(kind_e kind, logic [CHAR_W-1:0] ch,
                                             logic [LOC_W-1:0] addr);
    report_t           rep;
    int unsigned       col;
    int unsigned       row;
    int unsigned       i;
    logic [CELL_W-1:0] blank;
    rep   = '0;
    col   = cursor_col_mirror;
    row   = cursor_row_mirror;
    blank = {attr_shadow, CH_SPACE};
    case (kind)
      KIND_PUT: begin
        if (ch == CH_BS) begin
          if (col != 0) col--;
        end else if (ch == CH_TAB) begin
          col = col + TAB_WIDTH - (col % TAB_WIDTH);
        end else if (ch == CH_CR) begin
          col = 0;
        end else if (ch == CH_LF) begin
          col = 0;
          row++;
        end else if (ch >= CH_SPACE && ch <= CH_DEL) begin
          screen_mirror[row * COLUMNS + col] = {attr_shadow, ch};
          col++;
        end
        // wrap to the next line
        if (col >= COLUMNS) begin
          col = 0;
          row++;
        end
        // scroll up one line and blank the bottom one
        if (row >= ROWS) begin
          for (i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_mirror[i] = screen_mirror[i + COLUMNS];
          for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_mirror[i] = blank;
          row          = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) screen_mirror[i] = blank;
        col = 0;
        row = 0;
      end
      KIND_READ: begin
        if (addr < CELL_COUNT) rep.cell_data = screen_mirror[addr];
      end
      default: begin
      end
    endcase
    cursor_col_mirror = col;
    cursor_row_mirror = row;
    rep.col = COL_W'(col);
    rep.row = ROW_W'(row);
    rep.loc = LOC_W'(row * COLUMNS + col);
    return rep;
  endfunction

  function automatic void check_report(string src, report_t want, report_t got);
    if (got.col !== want.col) begin
      $error("%s cursor_column: expected %0d, got %0d", src, want.col, got.col);
      fail_count++;
    end
    if (got.row !== want.row) begin
      $error("%s cursor_row: expected %0d, got %0d", src, want.row, got.row);
      fail_count++;
    end
    if (got.loc !== want.loc) begin
      $error("%s cursor_location: expected %0d, got %0d", src, want.loc, got.loc);
      fail_count++;
    end
    if (got.cell_data !== want.cell_data) begin
      $error("%s cell_data: expected %04h, got %04h", src, want.cell_data, got.cell_data);
      fail_count++;
    end
    if (got.scrolled !== want.scrolled) begin
      $error("%s scrolled: expected %0d, got %0d", src, want.scrolled, got.scrolled);
      fail_count++;
    end
  endfunction

  // Check reports, predict accepted items, track attribute writes, watch for hangs
  always @(posedge clk_i) begin : scoreboard
    report_t  got;
    pending_t entry;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_reports.size() == 0) begin
          $error("cursor report with nothing expected: %010h", got);
          fail_count++;
        end else begin
          entry = pending_reports.pop_front();
          check_report("predicted", entry.want, got);
          if (entry.typed) check_report("table", entry.typed_want, got);
          reports_checked++;
          if (got.scrolled) scrolls_seen++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        entry.want = advance_screen(kind_e'(s_axis_tuser), s_axis_tdata[7:0],
                                    s_axis_tdata[18:8]);
        entry.typed      = row_typed;
        entry.typed_want = row_want;
        pending_reports.push_back(entry);
      end
      if (psel && penable && pwrite && pready && paddr == ATTR_ADDR)
        attr_shadow = pwdata[ATTR_W-1:0];
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Result side: random stalls and one long hold-off while input keeps coming
  initial begin : report_sink
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && reports_checked >= 40) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until accepted; valid stays high for the next one
  task automatic offer_item(kind_e kind, logic [CHAR_W-1:0] ch, logic [LOC_W-1:0] addr,
                            logic typed, report_t want);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b0, addr, ch};
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic offer_put(logic [CHAR_W-1:0] ch);
    offer_item(KIND_PUT, ch, LOC_W'($urandom), 1'b0, HOME_EMPTY);
  endtask

  // Random traffic: mostly text and line control, some reads, rare clears
  task automatic offer_random_items(int unsigned count);
    int unsigned       pick;
    int unsigned       region;
    logic [LOC_W-1:0]  addr;
    logic [CHAR_W-1:0] ch;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom);
      addr = LOC_W'($urandom);
      if (pick < 40) begin
        offer_put(CHAR_W'($urandom_range(32, 127)));
      end else if (pick < 60) begin
        offer_put(CH_LF);
      end else if (pick < 64) begin
        offer_put(CH_CR);
      end else if (pick < 69) begin
        offer_put(CH_TAB);
      end else if (pick < 74) begin
        offer_put(CH_BS);
      end else if (pick < 79) begin
        offer_put(pick < 77 ? CHAR_W'($urandom_range(0, 31))
                            : CHAR_W'($urandom_range(128, 255)));
      end else if (pick < 93) begin
        region = $urandom_range(0, 9);
        if (region == 0)
          addr = LOC_W'($urandom_range(CELL_COUNT, 2047));
        else if (region < 5)
          addr = LOC_W'($urandom_range(0, CELL_COUNT - 1));
        else
          addr = LOC_W'(cursor_row_mirror * COLUMNS + $urandom_range(0, COLUMNS - 1));
        offer_item(KIND_READ, ch, addr, 1'b0, HOME_EMPTY);
      end else if (pick < 96) begin
        offer_item(KIND_NONE, ch, addr, 1'b0, HOME_EMPTY);
      end else begin
        offer_item(KIND_CLEAR, ch, addr, 1'b0, HOME_EMPTY);
      end
    end
  endtask

  // Stop offering and wait until every report has come back
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  // Write the text attribute while the block is idle
  task automatic retune_attribute(logic [ATTR_W-1:0] value);
    drain_reports();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {{(APB_DATA_W - ATTR_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned       i;
    logic [ATTR_W-1:0] attr_last;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_PUT;
    row_typed     <= 1'b0;
    row_want      <= HOME_EMPTY;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    for (i = 0; i < CELL_COUNT; i++) screen_mirror[i] = RESET_CELL;
    cursor_col_mirror = 0;
    cursor_row_mirror = 0;
    attr_shadow       = ATTR_RESET;
    idle_en           = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Table walk under the reset attribute
    for (i = 0; i < DIRECTED_N; i++)
      offer_item(directed_tbl[i].kind, directed_tbl[i].ch, directed_tbl[i].addr,
                 directed_tbl[i].typed, directed_tbl[i].want);

    // Short lines past the bottom, then wraps on the last row
    retune_attribute(8'h00);
    repeat (27) begin
      repeat ($urandom_range(0, 1)) offer_put(CHAR_W'($urandom_range(32, 127)));
      offer_put(CH_LF);
    end
    offer_put(CH_CR);
    repeat (9) offer_put(CH_TAB);
    repeat (8) offer_put(CHAR_W'($urandom_range(32, 127)));
    repeat (10) offer_put(CH_TAB);

    // Random traffic under the widest attribute
    retune_attribute(8'hFF);
    offer_random_items(40);

    // Closing stretch without idling
    attr_last = ATTR_W'($urandom_range(1, 254));
    retune_attribute(attr_last);
    idle_en = 1'b0;
    offer_random_items(15);
    drain_reports();
    repeat (END_SETTLE) @(posedge clk_i);

    $display("Covered %0d items and %0d cursor reports, %0d of them scrolls,",
             items_sent, reports_checked, scrolls_seen);
    $display("under text attributes 0F, 00, FF and %02h, with a %0d-cycle output hold.",
             attr_last, LONG_HOLD);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
